### rtl/cosine_similarity_engine_macros.svh
// Assertion macros for the cosine similarity engine checker
`ifndef COSINE_SIMILARITY_ENGINE_MACROS_SVH
`define COSINE_SIMILARITY_ENGINE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cse_pkg.sv
// Shared constants, command struct and arithmetic helpers for the cosine similarity engine
package cse_pkg;

  localparam int ELEM_W    = 16;               // element width, Q1.15
  localparam int PROD_W    = 2 * ELEM_W;       // exact product width
  localparam int ACC_W     = 48;               // saturating accumulator width
  localparam int ROOT_W    = ACC_W / 2;        // integer root width
  localparam int DEN_W     = 2 * ROOT_W;       // root product width
  localparam int SQ_STEPS  = ACC_W / 2;        // one result bit per step
  localparam int FRAC_SH   = 15;               // numerator scale, 2^14 plus one for rounding
  localparam int Q_W       = 15;               // quotient bits below the clamp point
  localparam int DIV_STEPS = Q_W;
  localparam int NUM_W     = 64;               // numerator and shifted divisor width
  localparam int SIM_W     = 16;
  localparam int SIM_ONE   = 16384;            // 1.0 in Q2.14
  localparam int CNT_W     = $clog2(SQ_STEPS);

  typedef struct packed {
    logic accept;    // a pair word is taken this cycle
    logic sq_load;   // load the root units from the accumulators
    logic sq_step;   // one digit of both roots
    logic den_load;  // register root_a * root_b
    logic num_load;  // build numerator, divisor and range check
    logic div_step;  // one quotient bit
    logic fin;       // register the result word, clear accumulators
  } cse_cmd_t;

  // saturating add: returns {hit, clamped sum}
  function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                             input logic signed [PROD_W-1:0] p);
    logic [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){p[PROD_W-1]}}, p};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return {1'b1, s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
    end
    return {1'b0, s[ACC_W-1:0]};
  endfunction

  // one step of the bit-pair integer square root: returns {x, res}
  function automatic logic [2*ACC_W-1:0] sq_step(input logic [ACC_W-1:0] x,
                                                 input logic [ACC_W-1:0] res,
                                                 input logic [ACC_W-1:0] bitv);
    logic [ACC_W:0]   t;
    logic [ACC_W-1:0] x_n;
    logic [ACC_W-1:0] r_n;
    t = {1'b0, res} + {1'b0, bitv};
    if ({1'b0, x} >= t) begin
      x_n = x - t[ACC_W-1:0];
      r_n = (res >> 1) + bitv;
    end else begin
      x_n = x;
      r_n = res >> 1;
    end
    return {x_n, r_n};
  endfunction

endpackage

### rtl/cse_ctrl.sv
// Sequencer for the cosine similarity engine: accept, roots, divide, result strobe
module cse_ctrl import cse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     last_pair,
  output logic     busy,
  output logic     out_valid,
  output cse_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WAIT = 3'd1;
  localparam logic [2:0] S_SQI  = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_NUM  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             vld_r;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = vld_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = start;
        if (start && last_pair) state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_SQI;  // last product lands in the accumulators
      S_SQI: begin
        cmd.sq_load = 1'b1;
        cnt_nxt     = CNT_W'(SQ_STEPS - 1);
        state_nxt   = S_SQ;
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (cnt_r == '0) state_nxt = S_MUL;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_MUL: begin
        cmd.den_load = 1'b1;
        state_nxt    = S_NUM;
      end
      S_NUM: begin
        cmd.num_load = 1'b1;
        cnt_nxt      = CNT_W'(DIV_STEPS - 1);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) state_nxt = S_FIN;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= cmd.fin;
    end
  end

endmodule

### rtl/cse_dp.sv
// Datapath: product stage, saturating accumulators, two root units, multiplier and divider
module cse_dp import cse_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cse_cmd_t                 cmd,
  input  logic signed [ELEM_W-1:0] elem_a,
  input  logic signed [ELEM_W-1:0] elem_b,
  output logic signed [SIM_W-1:0]  similarity,
  output logic                     zero_norm,
  output logic                     saturated
);

  // product stage
  logic                     p_vld_r;
  logic signed [PROD_W-1:0] prod_ab_r, prod_aa_r, prod_bb_r;

  // accumulators
  logic signed [ACC_W-1:0] dot_r, na_r, nb_r;
  logic signed [ACC_W-1:0] dot_nxt, na_nxt, nb_nxt;
  logic                    sat_r, sat_nxt;
  logic [ACC_W:0]          s_dot, s_na, s_nb;

  // roots
  logic [ACC_W-1:0]   xa_r, xb_r, ra_r, rb_r, bit_r;
  logic [2*ACC_W-1:0] st_a, st_b;
  logic               zero_r;

  // divide
  logic [DEN_W-1:0] den_r;
  logic [ACC_W-1:0] mag;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] rem_r, dsh_r;
  logic [Q_W-1:0]   q_r;
  logic             big_r, neg_r;
  logic [SIM_W-1:0] qc;
  logic [SIM_W-1:0] sim_mag;

  logic signed [SIM_W-1:0] sim_r;
  logic                    zero_out_r, sat_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else        p_vld_r <= cmd.accept;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prod_ab_r <= elem_a * elem_b;
      prod_aa_r <= elem_a * elem_a;
      prod_bb_r <= elem_b * elem_b;
    end
  end

  assign s_dot = sat_add(dot_r, prod_ab_r);
  assign s_na  = sat_add(na_r, prod_aa_r);
  assign s_nb  = sat_add(nb_r, prod_bb_r);

  always_comb begin
    dot_nxt = dot_r;
    na_nxt  = na_r;
    nb_nxt  = nb_r;
    sat_nxt = sat_r;
    if (cmd.fin) begin
      dot_nxt = '0;
      na_nxt  = '0;
      nb_nxt  = '0;
      sat_nxt = 1'b0;
    end else if (p_vld_r) begin
      dot_nxt = s_dot[ACC_W-1:0];
      na_nxt  = s_na[ACC_W-1:0];
      nb_nxt  = s_nb[ACC_W-1:0];
      sat_nxt = sat_r | s_dot[ACC_W] | s_na[ACC_W] | s_nb[ACC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
      sat_r <= 1'b0;
    end else begin
      dot_r <= dot_nxt;
      na_r  <= na_nxt;
      nb_r  <= nb_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign st_a = sq_step(xa_r, ra_r, bit_r);
  assign st_b = sq_step(xb_r, rb_r, bit_r);

  // both roots share one schedule
  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      xa_r   <= na_r;
      xb_r   <= nb_r;
      ra_r   <= '0;
      rb_r   <= '0;
      bit_r  <= ACC_W'(1) << (ACC_W - 2);
      zero_r <= na_r[ACC_W-1] || (na_r == '0) || nb_r[ACC_W-1] || (nb_r == '0);
    end else if (cmd.sq_step) begin
      xa_r  <= st_a[2*ACC_W-1:ACC_W];
      ra_r  <= st_a[ACC_W-1:0];
      xb_r  <= st_b[2*ACC_W-1:ACC_W];
      rb_r  <= st_b[ACC_W-1:0];
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.den_load) den_r <= ra_r[ROOT_W-1:0] * rb_r[ROOT_W-1:0];
  end

  assign mag = dot_r[ACC_W-1] ? (~dot_r + 1'b1) : dot_r;
  assign num = (NUM_W'(mag) << FRAC_SH) + NUM_W'(den_r);

  // restoring divide of num by 2*den, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.num_load) begin
      rem_r <= num;
      dsh_r <= NUM_W'(den_r) << DIV_STEPS;
      big_r <= num >= (NUM_W'(den_r) << (DIV_STEPS + 1));
      neg_r <= dot_r[ACC_W-1];
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[Q_W-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  assign qc      = (big_r || (q_r > Q_W'(SIM_ONE))) ? SIM_W'(SIM_ONE) : SIM_W'(q_r);
  assign sim_mag = neg_r ? (~qc + 1'b1) : qc;

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      sim_r      <= zero_r ? '0 : signed'(sim_mag);
      zero_out_r <= zero_r;
      sat_out_r  <= sat_r;
    end
  end

  assign similarity = sim_r;
  assign zero_norm  = zero_out_r;
  assign saturated  = sat_out_r;

endmodule

### rtl/cosine_similarity_engine.sv
// Top level of the cosine similarity engine: sequencer plus datapath
// Pairs: one word per cycle while busy is low; products are registered, then summed.
// Last pair: busy rises and stays high through the sequence (two parallel 24-step root units, one multiply,
//   a 15-step restoring divider); out_valid pulses one cycle, in the cycle busy falls.
// The next vector may start while out_valid is high.
// Reset (rst_n low, synchronous): accumulators and saturation flag cleared, engine idle, no strobe.
module cosine_similarity_engine import cse_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     start,
  output logic                     busy,
  input  logic signed [ELEM_W-1:0] in_elem_a,
  input  logic signed [ELEM_W-1:0] in_elem_b,
  input  logic                     in_last_pair,
  // result channel, one-cycle strobe, no back-pressure
  output logic                     out_valid,
  output logic signed [SIM_W-1:0]  out_similarity,
  output logic                     out_zero_norm,
  output logic                     out_saturated
);

  // command word from sequencer to datapath
  cse_cmd_t cmd;

  // Sequencer: idle/accept, wait for the last sum, root steps,
  // denominator, numerator setup, divide steps, result word.
  cse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_pair (in_last_pair),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Datapath: Q1.15 products into 48-bit saturating sums, floor roots,
  // dot * 2^14 / (root_a * root_b) rounded half away from zero, clamped to +-1.0.
  cse_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .elem_a     (in_elem_a),
    .elem_b     (in_elem_b),
    .similarity (out_similarity),
    .zero_norm  (out_zero_norm),
    .saturated  (out_saturated)
  );

endmodule

### rtl/cse_chk.sv
// Port-level checker for the cosine similarity engine, bound to the top level
`include "cosine_similarity_engine_macros.svh"

module cse_chk import cse_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic signed [ELEM_W-1:0] in_elem_a,
  input logic signed [ELEM_W-1:0] in_elem_b,
  input logic                     in_last_pair,
  input logic                     out_valid,
  input logic signed [SIM_W-1:0]  out_similarity,
  input logic                     out_zero_norm,
  input logic                     out_saturated
);

  `CSE_ASSERT_NEXT(a_last_busy, start && !busy && in_last_pair, busy, "last pair word did not raise busy")
  `CSE_ASSERT_NOW(a_strobe_idle, out_valid, !busy, "result word while still busy")
  `CSE_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid, "result strobe longer than one cycle")
  `CSE_ASSERT_NOW(a_zero_sim, out_valid && out_zero_norm, out_similarity == '0, "zero norm with nonzero similarity")
  `CSE_ASSERT_NOW(a_sim_range, out_valid, (out_similarity <= SIM_ONE) && (out_similarity >= -SIM_ONE), "similarity outside +-1.0")

endmodule

bind cosine_similarity_engine cse_chk u_chk (.*);
